// ----- rtl/ast_pkg.sv -----
package ast_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } act_t;

    // Control part of the token that walks down the cell chain
    typedef struct packed {
        logic valid;
        act_t action;
        logic found;
    } tok_ctl_t;

endpackage

// ----- rtl/array_set_table_unit.sv -----
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// request  | start & !busy           | action[1:0], value[31:0] (signed)
// result   | done (one-cycle strobe) | was_present, status, count[6:0], is_empty
//
// A request walks a chain of CAPACITY cells, one cell per cycle; the result
// strobe is registered from the token leaving the last cell, and busy drops
// in that strobe cycle, so the next request can be taken from the strobe
// cycle on, but not while one is still in the chain.
// Reset (rst_n low) empties the set; stored entries keep no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module array_set_table_unit #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               was_present,
    output logic               status,
    output logic [6:0]         count,
    output logic               is_empty
);
    import ast_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // chain links: link k feeds cell k, link CAPACITY is the chain end
    tok_ctl_t                 tok_link [CAPACITY+1];
    logic [ELEMENT_WIDTH-1:0] val_link [CAPACITY+1];
    logic [ELEMENT_WIDTH-1:0] ent      [CAPACITY];

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic             present_reg, present_next;
    logic             status_reg, status_next;
    logic             accept, full;
    tok_ctl_t         tail;

    assign accept = start && !busy_reg;
    assign full   = count_reg == CNT_W'(CAPACITY);

    // token injection; value is sign extended or cut to the element width
    assign tok_link[0] = '{valid: accept, action: act_t'(action), found: 1'b0};
    assign val_link[0] = ELEMENT_WIDTH'(value);

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] nbr;
        if (k == CAPACITY - 1)
        begin : g_last
            assign nbr = ent[k];    // vacated top slot, never read again
        end
        else
        begin : g_mid
            assign nbr = ent[k+1];
        end

        ast_cell #(
            .IDX    (k),
            .CNT_W  (CNT_W),
            .ELEM_W (ELEMENT_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count_reg),
            .tok_in    (tok_link[k]),
            .val_in    (val_link[k]),
            .nbr_entry (nbr),
            .tok_out   (tok_link[k+1]),
            .val_out   (val_link[k+1]),
            .entry     (ent[k])
        );
    end

    assign tail = tok_link[CAPACITY];

    // token leaves the chain: presence is final, settle count and result
    always_comb
    begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        present_next = present_reg;
        status_next  = status_reg;
        if (accept)
            busy_next = 1'b1;
        if (tail.valid)
        begin
            busy_next    = 1'b0;
            done_next    = 1'b1;
            present_next = tail.found;
            status_next  = 1'b0;
            unique case (tail.action)
                ACT_INSERT:
                begin
                    if (!tail.found)
                    begin
                        if (full)
                            status_next = 1'b1;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_ERASE:
                begin
                    if (tail.found)
                        count_next = count_reg - CNT_W'(1);
                end
                ACT_FIND:  count_next = count_reg;
                ACT_CLEAR: count_next = '0;
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        present_reg <= present_next;
        status_reg  <= status_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign was_present = present_reg;
    assign status      = status_reg;
    assign count       = 7'(count_reg);
    assign is_empty    = count_reg == '0;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result without a request in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg |-> !present_reg && count_reg == CNT_W'(CAPACITY))
        else $error("reject with present value or non-full set");

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("token left chain while idle");

endmodule

// ----- rtl/ast_cell.sv -----
module ast_cell #(
    parameter int IDX    = 0,
    parameter int CNT_W  = 7,
    parameter int ELEM_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   count,
    input  ast_pkg::tok_ctl_t  tok_in,
    input  logic [ELEM_W-1:0]  val_in,
    input  logic [ELEM_W-1:0]  nbr_entry,
    output ast_pkg::tok_ctl_t  tok_out,
    output logic [ELEM_W-1:0]  val_out,
    output logic [ELEM_W-1:0]  entry
);
    import ast_pkg::*;

    logic [ELEM_W-1:0] entry_reg, entry_next;
    tok_ctl_t          tok_reg, tok_next;
    logic [ELEM_W-1:0] val_reg;
    logic              live, slot, match, found_now;

    assign live      = CNT_W'(IDX) < count;
    assign slot      = CNT_W'(IDX) == count;
    assign match     = tok_in.valid && live && (entry_reg == val_in);
    assign found_now = tok_in.found || match;

    always_comb
    begin
        entry_next = entry_reg;
        if (tok_in.valid)
        begin
            // erase: this entry and every later live one pull from the neighbor
            if (tok_in.action == ACT_ERASE && live && found_now)
                entry_next = nbr_entry;
            // insert: first free slot; found is final once past the live cells
            if (tok_in.action == ACT_INSERT && slot && !tok_in.found)
                entry_next = val_in;
        end
        tok_next       = tok_in;
        tok_next.found = found_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        val_reg   <= val_in;
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign entry   = entry_reg;

endmodule
